[design/rtt_pkg.sv]
// ----------------------------------------------------------------------------
// rtt_pkg: shared types and constants of the retransmit timer table
// Action and result codes, the entry record, and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

	localparam int ACTION_W    = 3;
	localparam int IDX_IN_W    = 4;
	localparam int INTERVAL_W  = 16;
	localparam int ATT_W       = 8;
	localparam int TYPE_W      = 8;
	localparam int PORT_W      = 16;
	localparam int TIME_W      = 32;
	localparam int KIND_W      = 3;
	localparam int ENTRIES_DEF = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC  = 3'd0,
		ACT_TICK   = 3'd1,
		ACT_RESP   = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_UPDATE = 3'd4
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE    = 3'd0,
		KIND_FULL    = 3'd1,
		KIND_SEND    = 3'd2,
		KIND_TIMEOUT = 3'd3,
		KIND_MATCH   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_OP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0]     deadline;
		logic [INTERVAL_W-1:0] interval;
		logic [ATT_W-1:0]      attempts;
		logic [TYPE_W-1:0]     etype;
		logic [PORT_W-1:0]     sender;
		logic [PORT_W-1:0]     receiver;
		logic                  notify;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic op_write;
		logic fin_push;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_scan;
		logic scan_done;
		logic out_free;
	} ctl_sts_t;

endpackage

`default_nettype wire

[design/rtt_controller.sv]
// ----------------------------------------------------------------------------
// rtt_controller: sequencer of the retransmit timer table
// Takes one word at a time, starts a scan or a single entry operation, and
// pushes the closing result once the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtt_controller (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  rtt_pkg::ctl_sts_t   sts,
	output rtt_pkg::ctl_cmd_t   cmd
);

	rtt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			rtt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = sts.in_scan ? rtt_pkg::ST_SCAN : rtt_pkg::ST_OP;
				end
			end
			rtt_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = rtt_pkg::ST_FIN;
				end
			end
			rtt_pkg::ST_OP: begin
				cmd.op_write = 1'b1;
				state_d      = rtt_pkg::ST_FIN;
			end
			rtt_pkg::ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin_push = 1'b1;
					state_d      = rtt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rtt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[design/rtt_datapath.sv]
// ----------------------------------------------------------------------------
// rtt_datapath: entry store, scan pipeline and result registers
// Reads one entry a cycle unless stalled, evaluates it the next cycle, and
// writes it back, and holds back one pending result to flag the final as last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtt_datapath #(
	parameter int ENTRIES = rtt_pkg::ENTRIES_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  rtt_pkg::ctl_cmd_t                    cmd,
	output rtt_pkg::ctl_sts_t                    sts,
	input  wire [rtt_pkg::ACTION_W-1:0]          action,
	input  wire [rtt_pkg::IDX_IN_W-1:0]          entry_index,
	input  wire [rtt_pkg::INTERVAL_W-1:0]        resend_interval,
	input  wire [rtt_pkg::ATT_W-1:0]             attempts,
	input  wire [rtt_pkg::TYPE_W-1:0]            response_type,
	input  wire [rtt_pkg::PORT_W-1:0]            sender_port,
	input  wire [rtt_pkg::PORT_W-1:0]            receiver_port,
	input  wire                                  notify_on_timeout,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [rtt_pkg::KIND_W-1:0]           kind,
	output logic [rtt_pkg::IDX_IN_W-1:0]         entry_index_res,
	output logic                                 last
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PTR_W = $clog2(ENTRIES + 1);

	// captured word
	rtt_pkg::action_t                 act_q;
	logic [rtt_pkg::IDX_IN_W-1:0]     idx_in_q;
	logic [rtt_pkg::INTERVAL_W-1:0]   ival_q;
	logic [rtt_pkg::ATT_W-1:0]        att_q;
	logic [rtt_pkg::TYPE_W-1:0]       type_q;
	logic [rtt_pkg::PORT_W-1:0]       snd_q;
	logic [rtt_pkg::PORT_W-1:0]       rcv_q;
	logic                             ntf_q;

	logic [rtt_pkg::TIME_W-1:0]       time_q;
	logic [ENTRIES-1:0]               valid_q;
	rtt_pkg::entry_t                  entry_mem [ENTRIES];

	logic [PTR_W-1:0]                 ptr_q;
	logic                             s1_v_q;
	logic [IDX_W-1:0]                 idx_s1;
	rtt_pkg::entry_t                  rd_s1;

	logic                             pend_v_q;
	rtt_pkg::kind_t                   pend_kind_q;
	logic [rtt_pkg::IDX_IN_W-1:0]     pend_idx_q;
	logic [rtt_pkg::CNT_W-1:0]        cnt_q;

	logic                             out_v_q;
	rtt_pkg::kind_t                   out_kind_q;
	logic [rtt_pkg::IDX_IN_W-1:0]     out_idx_q;
	logic                             out_last_q;

	logic                             ptr_end;
	logic [IDX_W-1:0]                 rd_addr;
	logic                             cur_v;
	logic                             due;
	logic [rtt_pkg::TIME_W-1:0]       rearm;
	logic                             res_fire;
	rtt_pkg::kind_t                   res_kind;
	logic                             record;
	logic                             stall;
	logic                             adv;
	logic                             scan_wr;
	logic                             scan_set;
	logic                             scan_clr;
	logic                             alloc_found;
	rtt_pkg::entry_t                  scan_data;
	rtt_pkg::entry_t                  item_entry;
	logic                             op_in_range;
	logic [IDX_W-1:0]                 op_addr;
	logic                             wr_en;
	logic [IDX_W-1:0]                 wr_addr;
	rtt_pkg::entry_t                  wr_data;
	logic                             rd_en;
	logic                             out_free;
	logic                             push_scan;
	rtt_pkg::action_t                 in_act;

	assign in_act   = rtt_pkg::action_t'(action);
	assign ptr_end  = (ptr_q == PTR_W'(ENTRIES));
	assign rd_addr  = ptr_q[IDX_W-1:0];
	assign out_free = !out_v_q || out_ready;

	assign sts.in_scan   = (in_act == rtt_pkg::ACT_ALLOC) || (in_act == rtt_pkg::ACT_TICK) ||
	                       (in_act == rtt_pkg::ACT_RESP);
	assign sts.scan_done = ptr_end && !s1_v_q;
	assign sts.out_free  = out_free;

	// new entry built from the captured word; deadline filled in per use
	always_comb begin
		item_entry.deadline = time_q + rtt_pkg::TIME_W'(ival_q);
		item_entry.interval = ival_q;
		item_entry.attempts = att_q;
		item_entry.etype    = type_q;
		item_entry.sender   = snd_q;
		item_entry.receiver = rcv_q;
		item_entry.notify   = ntf_q;
	end

	assign op_in_range = int'(idx_in_q) < ENTRIES;
	assign op_addr     = IDX_W'(idx_in_q);

	// evaluate the entry held in the read register rd_s1
	assign cur_v = valid_q[idx_s1];
	assign due   = (time_q >= rd_s1.deadline);
	assign rearm = time_q + rtt_pkg::TIME_W'(rd_s1.interval);

	always_comb begin
		res_fire    = 1'b0;
		res_kind    = rtt_pkg::KIND_NONE;
		scan_wr     = 1'b0;
		scan_set    = 1'b0;
		scan_clr    = 1'b0;
		alloc_found = 1'b0;
		scan_data   = rd_s1;
		if (s1_v_q) begin
			case (act_q)
				rtt_pkg::ACT_ALLOC: begin
					if (!cur_v) begin
						alloc_found = 1'b1;
						res_fire    = 1'b1;
						res_kind    = rtt_pkg::KIND_SEND;
						scan_wr     = 1'b1;
						scan_set    = 1'b1;
						scan_data   = item_entry;
					end
				end
				rtt_pkg::ACT_TICK: begin
					if (cur_v && due) begin
						if (rd_s1.attempts == '0) begin
							scan_clr = 1'b1;
							if (rd_s1.notify) begin
								res_fire = 1'b1;
								res_kind = rtt_pkg::KIND_TIMEOUT;
							end
						end else begin
							scan_wr            = 1'b1;
							scan_data.attempts = rd_s1.attempts - 1'b1;
							scan_data.deadline = rearm;
							res_fire           = 1'b1;
							res_kind           = rtt_pkg::KIND_SEND;
						end
					end
				end
				rtt_pkg::ACT_RESP: begin
					if (cur_v && rd_s1.etype == type_q && rd_s1.sender == snd_q &&
					    rd_s1.receiver == rcv_q) begin
						res_fire = 1'b1;
						res_kind = rtt_pkg::KIND_MATCH;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// results past the cap still update the table but are not reported
	assign record    = res_fire && (cnt_q < rtt_pkg::CNT_W'(rtt_pkg::MAX_RESULTS));
	assign stall     = s1_v_q && record && pend_v_q && !out_free;
	assign adv       = s1_v_q && !stall;
	assign push_scan = adv && record && pend_v_q;
	assign rd_en     = !cmd.capture && !stall && !ptr_end && !(adv && alloc_found);

	// single write port shared by scan write-back and update
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = scan_data;
		if (cmd.op_write) begin
			wr_en   = (act_q == rtt_pkg::ACT_UPDATE) && op_in_range;
			wr_addr = op_addr;
			wr_data = item_entry;
			wr_data.deadline = time_q;
		end else if (adv) begin
			wr_en = scan_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1  <= entry_mem[rd_addr];
			idx_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q    <= in_act;
			idx_in_q <= entry_index;
			ival_q   <= resend_interval;
			att_q    <= attempts;
			type_q   <= response_type;
			snd_q    <= sender_port;
			rcv_q    <= receiver_port;
			ntf_q    <= notify_on_timeout;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			valid_q  <= '0;
			ptr_q    <= PTR_W'(ENTRIES);
			s1_v_q   <= 1'b0;
			pend_v_q <= 1'b0;
			cnt_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				if (in_act == rtt_pkg::ACT_TICK) begin
					time_q <= time_q + 1'b1;
				end
				ptr_q    <= sts.in_scan ? '0 : PTR_W'(ENTRIES);
				s1_v_q   <= 1'b0;
				pend_v_q <= 1'b0;
				cnt_q    <= '0;
			end else if (!stall) begin
				if (adv && alloc_found) begin
					// stop at the first free entry; drop the read in flight
					ptr_q  <= PTR_W'(ENTRIES);
					s1_v_q <= 1'b0;
				end else begin
					s1_v_q <= !ptr_end;
					if (!ptr_end) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
			end

			if (adv && scan_set) begin
				valid_q[idx_s1] <= 1'b1;
			end
			if (adv && scan_clr) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (cmd.op_write && op_in_range) begin
				if (act_q == rtt_pkg::ACT_UPDATE) begin
					valid_q[op_addr] <= 1'b1;
				end else if (act_q == rtt_pkg::ACT_REMOVE) begin
					valid_q[op_addr] <= 1'b0;
				end
			end

			if (adv && record) begin
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + 1'b1;
			end else if (cmd.fin_push) begin
				pend_v_q <= 1'b0;
			end

			if (cmd.fin_push || push_scan) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && record) begin
			pend_kind_q <= res_kind;
			pend_idx_q  <= rtt_pkg::IDX_IN_W'(idx_s1);
		end
		if (cmd.fin_push) begin
			out_last_q <= 1'b1;
			if (pend_v_q) begin
				out_kind_q <= pend_kind_q;
				out_idx_q  <= pend_idx_q;
			end else begin
				out_kind_q <= (act_q == rtt_pkg::ACT_ALLOC) ? rtt_pkg::KIND_FULL
				                                            : rtt_pkg::KIND_NONE;
				out_idx_q  <= '0;
			end
		end else if (push_scan) begin
			out_last_q <= 1'b0;
			out_kind_q <= pend_kind_q;
			out_idx_q  <= pend_idx_q;
		end
	end

	assign out_valid       = out_v_q;
	assign kind            = out_kind_q;
	assign entry_index_res = out_idx_q;
	assign last            = out_last_q;

endmodule

`default_nettype wire

[design/retransmit_timer_table.sv]
// ----------------------------------------------------------------------------
// retransmit_timer_table: table of packets awaiting a response
// Allocate, tick, response, remove and update on a table of timed entries.
// ----------------------------------------------------------------------------
// One word is in work at a time. Tick and response scan every entry, one per
// cycle unless a result stalls, through the entry store's single read port;
// allocate stops at the lowest free entry, or scans every entry when the table
// is full. Remove, update and unknown actions need no scan. A scan that has
// more than one result to report waits whenever the output side holds back a
// word, and every word waits for the output register before it closes. The
// last result of a word is marked with last. The next word is taken while
// that last result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module retransmit_timer_table #(
	parameter int ENTRIES = rtt_pkg::ENTRIES_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire [rtt_pkg::ACTION_W-1:0]          action,
	input  wire [rtt_pkg::IDX_IN_W-1:0]          entry_index,
	input  wire [rtt_pkg::INTERVAL_W-1:0]        resend_interval,
	input  wire [rtt_pkg::ATT_W-1:0]             attempts,
	input  wire [rtt_pkg::TYPE_W-1:0]            response_type,
	input  wire [rtt_pkg::PORT_W-1:0]            sender_port,
	input  wire [rtt_pkg::PORT_W-1:0]            receiver_port,
	input  wire                                  notify_on_timeout,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [rtt_pkg::KIND_W-1:0]           kind,
	output logic [rtt_pkg::IDX_IN_W-1:0]         entry_index_res,
	output logic                                 last
);

	rtt_pkg::ctl_cmd_t cmd;
	rtt_pkg::ctl_sts_t sts;

	rtt_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rtt_datapath #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.action            (action),
		.entry_index       (entry_index),
		.resend_interval   (resend_interval),
		.attempts          (attempts),
		.response_type     (response_type),
		.sender_port       (sender_port),
		.receiver_port     (receiver_port),
		.notify_on_timeout (notify_on_timeout),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.kind              (kind),
		.entry_index_res   (entry_index_res),
		.last              (last)
	);

endmodule

`default_nettype wire

[design/rtt_checker.sv]
// ----------------------------------------------------------------------------
// rtt_checker: port-level checks of the retransmit timer table
// Watches the handshakes and result words at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtt_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [rtt_pkg::KIND_W-1:0]    kind,
	input wire [rtt_pkg::IDX_IN_W-1:0]  entry_index_res,
	input wire                          last
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) &&
		$stable(entry_index_res) && $stable(last))
		else $error("result word changed while stalled");

	// one word in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted while previous one in work");

	// quiet and full results close their word and name no entry
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == rtt_pkg::KIND_NONE || kind == rtt_pkg::KIND_FULL) |->
		last && entry_index_res == '0)
		else $error("quiet or full result malformed");

	// a new word starts only after the previous one has pushed its last result
	a_start_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || last)
		else $error("word accepted before previous results were closed");

endmodule

bind retransmit_timer_table rtt_checker u_rtt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.kind            (kind),
	.entry_index_res (entry_index_res),
	.last            (last)
);

`default_nettype wire
